// ===== rtl/ordered_list_engine_macros.svh =====
// Assertion macros for the list engine RTL.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define OLE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered_list_engine check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered_list_engine check failed");

`endif

// ===== rtl/ole_pkg.sv =====
package ole_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT   = 3'd0,
      OP_PUSH_BACK    = 3'd1,
      OP_INSERT_POS   = 3'd2,
      OP_DELETE_POS   = 3'd3,
      OP_DELETE_VALUE = 3'd4,
      OP_DUMP         = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BADPOS   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_SEARCH,
      S_DUMP
   } state_type;

endpackage

// ===== rtl/ole_channels.sv =====
interface ole_req_bus;
   logic                                  valid;
   logic                                  ready;
   logic        [ole_pkg::OPCODE_W-1:0]   opcode;
   logic signed [ole_pkg::VALUE_W-1:0]    item_value;
   logic        [ole_pkg::POS_W-1:0]      position;

   modport source (output valid, opcode, item_value, position, input ready);
   modport sink   (input valid, opcode, item_value, position, output ready);
endinterface

interface ole_rsp_bus;
   logic                                  valid;
   logic                                  ready;
   logic        [ole_pkg::STATUS_W-1:0]   status;
   logic signed [ole_pkg::VALUE_W-1:0]    entry_value;
   logic        [ole_pkg::POS_W-1:0]      entry_index;
   logic                                  last;

   modport source (output valid, status, entry_value, entry_index, last, input ready);
   modport sink   (input valid, status, entry_value, entry_index, last, output ready);
endinterface

// ===== rtl/ordered_list_engine.sv =====
// Push, insert and delete answer after their shift; inserts and deletes move one entry
// per cycle through the single port pair of the entry store.
// Delete by value scans one entry per cycle before the shift.
// A dump emits one beat per cycle once the first entry is read from the store, unless the sink stalls.
// Rejected operations answer in the cycle after acceptance. One item is in work at a time.
// Synchronous reset empties the list and drops any pending beat; stored entries are not cleared.
`include "ordered_list_engine_macros.svh"

module ordered_list_engine (
   input  logic       clock,
   input  logic       reset,
   ole_req_bus.sink   req_if,
   ole_rsp_bus.source rsp_if
);

   localparam int CNT_W = ole_pkg::CNT_W;

   ole_pkg::state_type                  state_ff, state_in;
   logic        [CNT_W-1:0]             idx_ff, idx_in;
   logic        [CNT_W-1:0]             slot_ff, slot_in;
   logic        [CNT_W-1:0]             count_ff, count_in;
   logic signed [ole_pkg::VALUE_W-1:0]  value_ff, value_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   ole_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic signed [ole_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic        [ole_pkg::POS_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                mem_we;
   logic        [ole_pkg::ADDR_W-1:0]   mem_waddr;
   logic signed [ole_pkg::VALUE_W-1:0]  mem_wdata;
   logic        [ole_pkg::ADDR_W-1:0]   mem_raddr;
   logic signed [ole_pkg::VALUE_W-1:0]  mem_rdata;
   logic        [CNT_W-1:0]             raddr_full;

   logic                                out_free;
   logic                                req_ready;
   logic                                accept;
   logic                                is_full;
   logic                                is_empty;
   logic        [ole_pkg::POS_W-1:0]    count_ext;
   logic                                ins_pos_ok;
   logic                                del_pos_ok;
   logic        [CNT_W-1:0]             pos_slot;
   logic        [CNT_W-1:0]             idx_next;
   logic                                respond_now;
   ole_pkg::status_type                 respond_status;

   ole_store u_store (
      .clock      (clock),
      .write_en   (mem_we),
      .write_addr (mem_waddr),
      .write_data (mem_wdata),
      .read_addr  (mem_raddr),
      .read_data  (mem_rdata)
   );

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign req_ready  = (state_ff == ole_pkg::S_IDLE) && out_free;
   assign accept     = req_if.valid && req_ready;
   assign is_full    = (count_ff == CNT_W'(ole_pkg::CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign count_ext  = ole_pkg::POS_W'(count_ff);
   assign ins_pos_ok = (req_if.position != '0) && (req_if.position <= count_ext + 7'd1);
   assign del_pos_ok = (req_if.position != '0) && (req_if.position <= count_ext);
   assign pos_slot   = CNT_W'(req_if.position - 7'd1);
   assign idx_next   = idx_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ole_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      slot_in        = slot_ff;
      count_in       = count_ff;
      value_in       = value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff[ole_pkg::ADDR_W-1:0];
      mem_wdata      = mem_rdata;
      respond_now    = 1'b0;
      respond_status = ole_pkg::ST_OK;

      unique case (state_ff)
         ole_pkg::S_IDLE: begin
            if (accept) begin
               value_in = req_if.item_value;
               unique case (ole_pkg::opcode_type'(req_if.opcode))
                  ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_PUSH_BACK,
                  ole_pkg::OP_INSERT_POS: begin
                     if (is_full) begin
                        respond_now    = 1'b1;
                        respond_status = ole_pkg::ST_FULL;
                     end else if ((req_if.opcode == ole_pkg::OP_INSERT_POS) && !ins_pos_ok) begin
                        respond_now    = 1'b1;
                        respond_status = ole_pkg::ST_BADPOS;
                     end else begin
                        state_in = ole_pkg::S_SHIFT_UP;
                        idx_in   = count_ff;
                        if (req_if.opcode == ole_pkg::OP_PUSH_FRONT) begin
                           slot_in = '0;
                        end else if (req_if.opcode == ole_pkg::OP_PUSH_BACK) begin
                           slot_in = count_ff;
                        end else begin
                           slot_in = pos_slot;
                        end
                     end
                  end
                  ole_pkg::OP_DELETE_POS: begin
                     if (is_empty) begin
                        respond_now    = 1'b1;
                        respond_status = ole_pkg::ST_EMPTY;
                     end else if (!del_pos_ok) begin
                        respond_now    = 1'b1;
                        respond_status = ole_pkg::ST_BADPOS;
                     end else begin
                        state_in = ole_pkg::S_SHIFT_DOWN;
                        idx_in   = pos_slot;
                     end
                  end
                  ole_pkg::OP_DELETE_VALUE: begin
                     if (is_empty) begin
                        respond_now    = 1'b1;
                        respond_status = ole_pkg::ST_EMPTY;
                     end else begin
                        state_in = ole_pkg::S_SEARCH;
                        idx_in   = '0;
                     end
                  end
                  ole_pkg::OP_DUMP: begin
                     if (is_empty) begin
                        respond_now    = 1'b1;
                        respond_status = ole_pkg::ST_EMPTY;
                     end else begin
                        state_in = ole_pkg::S_DUMP;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     respond_now = 1'b1;
                  end
               endcase
            end
         end
         ole_pkg::S_SHIFT_UP: begin
            if (idx_ff != slot_ff) begin
               mem_we = 1'b1;
               idx_in = idx_ff - CNT_W'(1);
            end else if (out_free) begin
               mem_we      = 1'b1;
               mem_waddr   = slot_ff[ole_pkg::ADDR_W-1:0];
               mem_wdata   = value_ff;
               count_in    = count_ff + CNT_W'(1);
               respond_now = 1'b1;
               state_in    = ole_pkg::S_IDLE;
            end
         end
         ole_pkg::S_SHIFT_DOWN: begin
            if (idx_next < count_ff) begin
               mem_we = 1'b1;
               idx_in = idx_next;
            end else if (out_free) begin
               count_in    = count_ff - CNT_W'(1);
               respond_now = 1'b1;
               state_in    = ole_pkg::S_IDLE;
            end
         end
         ole_pkg::S_SEARCH: begin
            if (mem_rdata == value_ff) begin
               state_in = ole_pkg::S_SHIFT_DOWN;
            end else if (idx_next == count_ff) begin
               if (out_free) begin
                  respond_now    = 1'b1;
                  respond_status = ole_pkg::ST_NOTFOUND;
                  state_in       = ole_pkg::S_IDLE;
               end
            end else begin
               idx_in = idx_next;
            end
         end
         ole_pkg::S_DUMP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ole_pkg::ST_OK;
               rsp_value_in  = mem_rdata;
               rsp_index_in  = ole_pkg::POS_W'(idx_next);
               rsp_last_in   = (idx_next == count_ff);
               if (idx_next == count_ff) begin
                  state_in = ole_pkg::S_IDLE;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         default: begin
            state_in = ole_pkg::S_IDLE;
         end
      endcase

      if (respond_now) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = respond_status;
         rsp_value_in  = '0;
         rsp_index_in  = '0;
         rsp_last_in   = 1'b1;
      end
   end

   // The store is read at the entry that the next state will need, through its registered read port.
   always_comb begin
      unique case (state_in)
         ole_pkg::S_SHIFT_UP:   raddr_full = idx_in - CNT_W'(1);
         ole_pkg::S_SHIFT_DOWN: raddr_full = idx_in + CNT_W'(1);
         default:               raddr_full = idx_in;
      endcase
   end

   assign mem_raddr = raddr_full[ole_pkg::ADDR_W-1:0];

   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.entry_value = rsp_value_ff;
   assign rsp_if.entry_index = rsp_index_ff;
   assign rsp_if.last        = rsp_last_ff;

   `OLE_ASSERT_SAME(a_count_in_range, 1'b1, count_ff <= CNT_W'(ole_pkg::CAPACITY))
   `OLE_ASSERT_SAME(a_count_moves_with_answer, !$past(reset) && !$stable(count_ff), rsp_valid_ff && rsp_last_ff)
   `OLE_ASSERT_SAME(a_error_beat_is_final, rsp_valid_ff && (rsp_status_ff != ole_pkg::ST_OK), rsp_last_ff && (rsp_index_ff == '0))
   `OLE_ASSERT_SAME(a_write_only_in_shift, mem_we, (state_ff == ole_pkg::S_SHIFT_UP) || (state_ff == ole_pkg::S_SHIFT_DOWN))
   `OLE_ASSERT_NEXT(a_accept_leaves_idle, accept, (state_ff != ole_pkg::S_IDLE) || rsp_valid_ff)

endmodule

// ===== rtl/ole_store.sv =====
module ole_store (
   input  logic                               clock,
   input  logic                               write_en,
   input  logic        [ole_pkg::ADDR_W-1:0]  write_addr,
   input  logic signed [ole_pkg::VALUE_W-1:0] write_data,
   input  logic        [ole_pkg::ADDR_W-1:0]  read_addr,
   output logic signed [ole_pkg::VALUE_W-1:0] read_data
);

   logic signed [ole_pkg::VALUE_W-1:0] mem [ole_pkg::CAPACITY];
   logic signed [ole_pkg::VALUE_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== sim/tb.sv =====
module tb;

   localparam logic [ole_pkg::OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [ole_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic [ole_pkg::OPCODE_W-1:0]       opcode;
      logic signed [ole_pkg::VALUE_W-1:0] item_value;
      logic [ole_pkg::POS_W-1:0]          position;
      bit                                 wait_idle;
   } list_op_type;

   typedef struct {
      logic [ole_pkg::STATUS_W-1:0]       status;
      logic signed [ole_pkg::VALUE_W-1:0] entry_value;
      logic [ole_pkg::POS_W-1:0]          entry_index;
      logic                               last;
   } list_answer_type;

   logic clock = 1'b0;
   logic reset;

   ole_req_bus req_bus ();
   ole_rsp_bus rsp_bus ();

   ordered_list_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   list_op_type                        op_backlog[$];
   list_answer_type                    answers_due[$];
   logic signed [ole_pkg::VALUE_W-1:0] list_model[$];

   list_op_type     op_next;
   list_answer_type answer_want;
   int              ops_offered;
   int              ops_taken;
   int              answers_seen;
   int              error_count;
   int              req_idle_left;
   int              req_quiet_left;
   int              rsp_hold_left;
   int              rsp_quiet_left;
   bit              long_hold_done;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, and now and then a stretch with none at all.
   function automatic int pick_idle(inout int quiet_left);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if (roll < 4) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 65) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Values come often from a small set so that deletes by value find matches.
   function automatic logic signed [ole_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3, 4, 5: return $signed($urandom_range(0, 7)) - 32'sd3;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic [ole_pkg::POS_W-1:0] pick_position(input int len);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return ole_pkg::POS_W'($urandom_range(1, len + 1));
      if (roll < 80) return '0;
      if (roll < 90) return ole_pkg::POS_W'(len + $urandom_range(1, 2));
      return ole_pkg::POS_W'($urandom_range(0, 127));
   endfunction

   task automatic queue_op(input logic [ole_pkg::OPCODE_W-1:0] op,
                           input logic signed [ole_pkg::VALUE_W-1:0] v,
                           input logic [ole_pkg::POS_W-1:0] p, input bit wait_idle);
      list_op_type item;
      item = '{op, v, p, wait_idle};
      op_backlog.push_back(item);
   endtask

   task automatic apply_list_op(input logic [ole_pkg::OPCODE_W-1:0] op,
                                input logic signed [ole_pkg::VALUE_W-1:0] v,
                                input logic [ole_pkg::POS_W-1:0] p);
      list_answer_type answer;
      logic [ole_pkg::STATUS_W-1:0] st;
      int n;
      int slot;
      n = list_model.size();
      st = ole_pkg::ST_OK;
      slot = -1;
      case (op)
         ole_pkg::OP_PUSH_FRONT: begin
            if (n >= ole_pkg::CAPACITY) st = ole_pkg::ST_FULL;
            else list_model.push_front(v);
         end
         ole_pkg::OP_PUSH_BACK: begin
            if (n >= ole_pkg::CAPACITY) st = ole_pkg::ST_FULL;
            else list_model.push_back(v);
         end
         ole_pkg::OP_INSERT_POS: begin
            if (n >= ole_pkg::CAPACITY) st = ole_pkg::ST_FULL;
            else if (p < 1 || p > n + 1) st = ole_pkg::ST_BADPOS;
            else list_model.insert(int'(p) - 1, v);
         end
         ole_pkg::OP_DELETE_POS: begin
            if (n == 0) st = ole_pkg::ST_EMPTY;
            else if (p < 1 || p > n) st = ole_pkg::ST_BADPOS;
            else list_model.delete(int'(p) - 1);
         end
         ole_pkg::OP_DELETE_VALUE: begin
            if (n == 0) begin
               st = ole_pkg::ST_EMPTY;
            end else begin
               for (int i = 0; i < n; i++)
                  if (slot < 0 && list_model[i] == v) slot = i;
               if (slot < 0) st = ole_pkg::ST_NOTFOUND;
               else list_model.delete(slot);
            end
         end
         ole_pkg::OP_DUMP: begin
            if (n == 0) begin
               st = ole_pkg::ST_EMPTY;
            end else begin
               for (int i = 0; i < n; i++) begin
                  answer = '{ole_pkg::ST_OK, list_model[i], ole_pkg::POS_W'(i + 1),
                             i == n - 1};
                  answers_due.push_back(answer);
               end
               return;
            end
         end
         default: ;
      endcase
      answer = '{st, 32'sd0, 7'd0, 1'b1};
      answers_due.push_back(answer);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && ops_taken != ops_offered) begin
         req_bus.valid <= 1'b1;
      end else if (req_idle_left > 0) begin
         req_idle_left--;
         req_bus.valid <= 1'b0;
      end else if (op_backlog.size() > 0 &&
                   !(op_backlog[0].wait_idle && answers_due.size() > 0)) begin
         op_next = op_backlog.pop_front();
         req_bus.opcode     <= op_next.opcode;
         req_bus.item_value <= op_next.item_value;
         req_bus.position   <= op_next.position;
         req_bus.valid      <= 1'b1;
         ops_offered++;
         req_idle_left = pick_idle(req_quiet_left);
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Once in the run, while an item waits at the input, the receiver stops for a long stretch
   // so that the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (!long_hold_done && answers_seen >= 60 &&
                   req_bus.valid && !req_bus.ready) begin
         long_hold_done = 1'b1;
         rsp_hold_left = 300;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_hold_left = pick_idle(rsp_quiet_left);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            apply_list_op(req_bus.opcode, req_bus.item_value, req_bus.position);
            ops_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            answers_seen++;
            if (answers_due.size() == 0) begin
               $error("result beat with nothing expected");
               error_count++;
            end else begin
               answer_want = answers_due.pop_front();
               compare_field("status", 32'(answer_want.status), 32'(rsp_bus.status));
               compare_field("entry_value", answer_want.entry_value, rsp_bus.entry_value);
               compare_field("entry_index", 32'(answer_want.entry_index),
                             32'(rsp_bus.entry_index));
               compare_field("last", 32'(answer_want.last), 32'(rsp_bus.last));
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int est_len;
      int seg;
      int seg_len;
      int k;
      int roll;
      bit grow;
      logic [ole_pkg::OPCODE_W-1:0] op;
      logic signed [ole_pkg::VALUE_W-1:0] v;
      logic [ole_pkg::POS_W-1:0] p;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = ole_pkg::OP_PUSH_FRONT;
      req_bus.item_value = '0;
      req_bus.position = '0;
      rsp_bus.ready = 1'b0;
      ops_offered = 0;
      ops_taken = 0;
      answers_seen = 0;
      error_count = 0;
      req_idle_left = 0;
      req_quiet_left = 0;
      rsp_hold_left = 0;
      rsp_quiet_left = 0;
      long_hold_done = 1'b0;

      queue_op(ole_pkg::OP_DUMP, 32'sd0, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_DELETE_POS, 32'sd0, 7'd1, 1'b0);
      queue_op(ole_pkg::OP_DELETE_VALUE, 32'sd0, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_PUSH_BACK, 32'sh8000_0000, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_INSERT_POS, 32'sd9, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_INSERT_POS, 32'sd9, 7'd4, 1'b0);
      queue_op(ole_pkg::OP_INSERT_POS, 32'sd5, 7'd3, 1'b0);
      queue_op(ole_pkg::OP_INSERT_POS, -32'sd1, 7'd1, 1'b0);
      queue_op(ole_pkg::OP_INSERT_POS, 32'sd0, 7'd2, 1'b0);
      queue_op(OP_SPARE_6, $signed($urandom()), 7'd127, 1'b0);
      queue_op(OP_SPARE_7, $signed($urandom()), 7'd1, 1'b0);
      queue_op(ole_pkg::OP_DUMP, 32'sd0, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_DELETE_POS, 32'sd0, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_DELETE_POS, 32'sd0, 7'd6, 1'b0);
      queue_op(ole_pkg::OP_DELETE_POS, 32'sd0, 7'd127, 1'b0);
      queue_op(ole_pkg::OP_DELETE_POS, 32'sd0, 7'd5, 1'b0);
      queue_op(ole_pkg::OP_DELETE_POS, 32'sd0, 7'd1, 1'b0);
      queue_op(ole_pkg::OP_DELETE_VALUE, 32'sh8000_0000, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_DELETE_VALUE, 32'sd12345, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_DELETE_VALUE, 32'sh7FFF_FFFF, 7'd0, 1'b0);
      queue_op(ole_pkg::OP_DUMP, 32'sd0, 7'd0, 1'b0);
      est_len = 2;

      // Growing and shrinking phases alternate so that the list runs full and empty again.
      for (seg = 0; seg < 9; seg++) begin
         grow = (seg % 2 == 0);
         seg_len = grow ? 18 : 12;
         for (k = 0; k < seg_len; k++) begin
            roll = $urandom_range(0, 99);
            v = pick_value();
            p = pick_position(est_len);
            if (roll < 3) begin
               op = roll[0] ? OP_SPARE_7 : OP_SPARE_6;
            end else if (roll < (grow ? 88 : 22)) begin
               case ($urandom_range(0, 2))
                  0: op = ole_pkg::OP_PUSH_FRONT;
                  1: op = ole_pkg::OP_PUSH_BACK;
                  default: op = ole_pkg::OP_INSERT_POS;
               endcase
               if (est_len < ole_pkg::CAPACITY &&
                   (op != ole_pkg::OP_INSERT_POS || (p >= 1 && p <= est_len + 1)))
                  est_len++;
            end else if (roll < 95) begin
               op = roll[0] ? ole_pkg::OP_DELETE_VALUE : ole_pkg::OP_DELETE_POS;
               if (est_len > 0 &&
                   (op == ole_pkg::OP_DELETE_VALUE || (p >= 1 && p <= est_len)))
                  est_len--;
            end else begin
               op = ole_pkg::OP_DUMP;
            end
            queue_op(op, v, p, k == 0 && (seg == 1 || $urandom_range(0, 3) == 0));
         end
         queue_op(ole_pkg::OP_DUMP, $signed($urandom()), ole_pkg::POS_W'($urandom()), 1'b0);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (op_backlog.size() > 0 || ops_taken != ops_offered || answers_due.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (error_count == 0 && answers_due.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== ordered_list_engine.f =====
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_channels.sv
rtl/ole_store.sv
rtl/ordered_list_engine.sv
sim/tb.sv
